// File: design/isf_pkg.sv
// Package: shared types, constants and the FNV-1a round for the fingerprint block.
package isf_pkg;

  localparam int unsigned MaxInstructions = 100000;
  localparam int unsigned CountW          = $clog2(MaxInstructions + 1);
  localparam int unsigned OutCountW       = 17;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned QueuePtrW       = $clog2(QueueDepth);

  localparam logic [63:0] FnvBasis    = 64'd14695981039346656037;
  // FNV prime is 2^40 + 0x1b3: one shift plus a 64x9 product
  localparam int unsigned FnvShift    = 40;
  localparam logic [8:0]  FnvPrimeLow = 9'h1b3;

  typedef enum logic [1:0] {
    WS_OPCODE,
    WS_REGS,
    WS_FLAGS,
    WS_IMM
  } word_sel_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FOLD,
    BK_EMIT
  } bk_state_e;

  // Classified instruction as it travels through the queue
  typedef struct packed {
    logic        has_instr;
    logic        fold_imm;
    logic        last;
    logic [15:0] opcode;
    logic [31:0] regs;
    logic [11:0] flags;
    logic [63:0] imm;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << FnvShift) + (x * {55'd0, FnvPrimeLow});
  endfunction

  function automatic logic [63:0] cmd_word(input cmd_t c, input word_sel_e sel);
    logic [63:0] w;
    case (sel)
      WS_OPCODE: w = {48'd0, c.opcode};
      WS_REGS:   w = {32'd0, c.regs};
      WS_FLAGS:  w = {52'd0, c.flags};
      WS_IMM:    w = c.imm;
      default:   w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: design/isf_if.sv
// Interfaces: instruction item channel and fingerprint result channel.
interface isf_item_if;
  logic        valid;
  logic        ready;
  logic        has_instruction;
  logic [15:0] opcode_id;
  logic [15:0] first_register;
  logic [15:0] second_register;
  logic        has_immediate;
  logic        has_memory_operand;
  logic [7:0]  instruction_kind;
  logic [63:0] immediate;
  logic        immediate_is_address;
  logic        last;

  modport source (
    output valid, has_instruction, opcode_id, first_register, second_register,
           has_immediate, has_memory_operand, instruction_kind, immediate,
           immediate_is_address, last,
    input  ready
  );
  modport sink (
    input  valid, has_instruction, opcode_id, first_register, second_register,
           has_immediate, has_memory_operand, instruction_kind, immediate,
           immediate_is_address, last,
    output ready
  );
endinterface

interface isf_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] fingerprint_hash;
  logic [16:0] instruction_count;

  modport source (output valid, fingerprint_hash, instruction_count, input ready);
  modport sink (input valid, fingerprint_hash, instruction_count, output ready);
endinterface

// File: design/isf_front.sv
// Front end: accepts instruction beats, packs the hash words, pushes to the queue.
module isf_front
  import isf_pkg::*;
(
  isf_item_if.sink item_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  assign item_i.ready = !q_status_i.full;

  // Empty beats that do not close a function change nothing: drop them here.
  assign push_o = item_i.valid && !q_status_i.full &&
                  (item_i.has_instruction || item_i.last);

  always_comb begin
    cmd_o.has_instr = item_i.has_instruction;
    cmd_o.fold_imm  = item_i.has_immediate && !item_i.immediate_is_address;
    cmd_o.last      = item_i.last;
    cmd_o.opcode    = item_i.opcode_id;
    cmd_o.regs      = {item_i.first_register, item_i.second_register};
    cmd_o.flags     = {item_i.instruction_kind, 2'b00,
                       item_i.has_memory_operand, item_i.has_immediate};
    cmd_o.imm       = item_i.immediate;
  end

endmodule

// File: design/isf_queue.sv
// Small FIFO of classified instructions between front and back end.
module isf_queue
  import isf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      push_data_i,
  input  logic      pop_i,
  output cmd_t      pop_data_o,
  output q_status_t status_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   fill_q, fill_d;
  logic                 do_push, do_pop;

  assign status_o.full  = (fill_q == (QueuePtrW + 1)'(QueueDepth));
  assign status_o.empty = (fill_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/isf_back.sv
// Back end: byte-serial FNV-1a engine, instruction counter and result register.
module isf_back
  import isf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  isf_result_if.source result_o
);

  bk_state_e          state_q, state_d;
  logic [63:0]        hash_q, hash_d;
  logic [CountW-1:0]  count_q, count_d;
  cmd_t               cmd_q, cmd_d;
  logic [63:0]        word_q, word_d;
  logic [2:0]         byte_q, byte_d;
  word_sel_e          widx_q, widx_d;
  word_sel_e          widx_next;
  word_sel_e          last_word;
  logic               out_valid_q, out_valid_d;
  logic [63:0]        out_hash_q, out_hash_d;
  logic [OutCountW-1:0] out_count_q, out_count_d;
  logic [CountW+OutCountW-1:0] count_ext;
  logic               fold_ok;
  logic               emit;
  logic               word_done;

  assign fold_ok   = cmd_i.has_instr && (count_q < CountW'(MaxInstructions));
  assign last_word = cmd_q.fold_imm ? WS_IMM : WS_FLAGS;
  assign widx_next = word_sel_e'(widx_q + 2'd1);
  assign word_done = (byte_q == 3'd7);
  assign count_ext = {{OutCountW{1'b0}}, count_q};

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    word_d      = word_q;
    byte_d      = byte_q;
    widx_d      = widx_q;
    pop_o       = 1'b0;
    emit        = 1'b0;
    out_valid_d = out_valid_q && !result_o.ready;
    out_hash_d  = out_hash_q;
    out_count_d = out_count_q;

    case (state_q)
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (fold_ok) begin
            word_d  = cmd_word(cmd_i, WS_OPCODE);
            byte_d  = '0;
            widx_d  = WS_OPCODE;
            state_d = BK_FOLD;
          end else if (cmd_i.last) begin
            state_d = BK_EMIT;
          end
        end
      end
      BK_FOLD: begin
        hash_d = fnv_step(hash_q, word_q[7:0]);
        word_d = word_q >> 8;
        byte_d = byte_q + 3'd1;
        if (word_done) begin
          if (widx_q == last_word) begin
            count_d = count_q + 1'b1;
            state_d = cmd_q.last ? BK_EMIT : BK_IDLE;
          end else begin
            widx_d = widx_next;
            word_d = cmd_word(cmd_q, widx_next);
          end
        end
      end
      BK_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          emit        = 1'b1;
          out_valid_d = 1'b1;
          out_hash_d  = hash_q;
          out_count_d = count_ext[OutCountW-1:0];
          hash_d      = FnvBasis;
          count_d     = '0;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      hash_q      <= FnvBasis;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    word_q      <= word_d;
    byte_q      <= byte_d;
    widx_q      <= widx_d;
    out_hash_q  <= out_hash_d;
    out_count_q <= out_count_d;
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.fingerprint_hash  = out_hash_q;
  assign result_o.instruction_count = out_count_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxInstructions))
    else $error("instruction count above limit");

  a_last_goes_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FOLD && word_done && widx_q == last_word && cmd_q.last)
      |=> state_q == BK_EMIT)
    else $error("closing instruction did not lead to emit");

  a_emit_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (hash_q == FnvBasis && count_q == '0 && out_valid_q))
    else $error("emit did not restart hash and count");

  a_pop_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BK_IDLE && !q_status_i.empty))
    else $error("dequeue outside idle");

endmodule

// File: design/instruction_stream_fingerprint.sv
// Top level: instruction stream fingerprint (running 64-bit FNV-1a over decoded instructions).
// Each instruction beat folds three 64-bit words (opcode id, register pair, flag word)
// and, when it carries a non-address immediate, a fourth, one byte per clock through a
// single FNV round (xor, then multiply by 2^40 + 0x1b3). The byte engine in the back end
// sets the rate: it dequeues an instruction only when idle and takes no new one until all
// its bytes are folded; a closing beat then loads the result register once it is free.
// Beats with no instruction and no last flag are dropped at the front and cost nothing;
// a closing beat without an instruction goes straight from the dequeue to the load. A
// four-entry queue lets the input side keep accepting while the engine works, and the
// result register holds a finished fingerprint until taken. After MaxInstructions further
// instructions in one function are ignored; the count saturates there, reported in 17 bits.
module instruction_stream_fingerprint
  import isf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  isf_item_if.sink     item_i,
  isf_result_if.source result_o
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;

  // classify and enqueue
  isf_front u_front (
    .item_i     (item_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decouples intake from the byte engine
  isf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .status_o    (q_status)
  );

  // hash engine, counter and result register
  isf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .result_o   (result_o)
  );

endmodule
